// ===== hdl/fdvx_pkg.sv =====
// ----------------------------------------------------------------------------
// fdvx_pkg - shared types and constants of the sync header deframer
// Result record, result kind codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package fdvx_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 29;
   localparam int IDX_W  = 8;

   // most length bytes in one frame (1 to 4); the last one carries 8 bits
   localparam int LEN_BYTES_MAX = 4;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_BODY   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_SYNC_FIRST  = 8'd0;
   localparam logic [IDX_W-1:0] CSR_SYNC_SECOND = 8'd1;

   // one result item
   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] packet_id;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  body_length;
      logic [BYTE_W-1:0] data_byte;
      logic              checksum_ok;
   } rsp_type;

   // result handed from the parser to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } res_type;

   // sync byte values
   typedef struct packed {
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] second;
   } sync_type;

endpackage

// ===== hdl/fdvx_csr.sv =====
// ----------------------------------------------------------------------------
// fdvx_csr - configuration registers
// Holds the two sync byte values; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module fdvx_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fdvx_pkg::IDX_W-1:0]    csr_index,
   input  logic [fdvx_pkg::BYTE_W-1:0]   csr_data,
   output fdvx_pkg::sync_type            sync
);

   fdvx_pkg::sync_type sync_ff, sync_in;
   logic               wr_en;

   // always ready: every write is accepted while csr_valid is high
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // index decode
   always_comb begin
      sync_in = sync_ff;
      if (wr_en) begin
         unique case (csr_index)
            fdvx_pkg::CSR_SYNC_FIRST:  sync_in.first  = csr_data;
            fdvx_pkg::CSR_SYNC_SECOND: sync_in.second = csr_data;
            default:                   sync_in        = sync_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= '0;
      end else begin
         sync_ff <= sync_in;
      end
   end

   assign sync = sync_ff;

endmodule

// ===== hdl/fdvx_parse.sv =====
// ----------------------------------------------------------------------------
// fdvx_parse - frame parser
// Per-byte state update: sync hunt, id, command, varint length, body
// countdown and XOR check. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module fdvx_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [fdvx_pkg::BYTE_W-1:0]   in_byte,
   input  fdvx_pkg::sync_type            sync,
   output fdvx_pkg::res_type             res
);

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_PKTID = 3'd2,
      PH_CMD   = 3'd3,
      PH_LEN   = 3'd4,
      PH_BODY  = 3'd5,
      PH_CSUM  = 3'd6
   } phase_type;

   localparam logic [1:0] LEN_LAST_CNT = 2'(fdvx_pkg::LEN_BYTES_MAX - 1);

   phase_type                     phase_ff, phase_in;
   logic [fdvx_pkg::BYTE_W-1:0]   pid_ff, pid_in;
   logic [fdvx_pkg::BYTE_W-1:0]   cmd_ff, cmd_in;
   logic [fdvx_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [1:0]                    len_cnt_ff, len_cnt_in;
   logic [fdvx_pkg::LEN_W-1:0]    rem_ff, rem_in;
   logic [fdvx_pkg::BYTE_W-1:0]   csum_ff, csum_in;

   logic                          len_full;
   logic [fdvx_pkg::BYTE_W-1:0]   len_bits;
   logic [4:0]                    len_shift;
   logic [fdvx_pkg::LEN_W-1:0]    len_part;
   logic [fdvx_pkg::LEN_W-1:0]    len_new;
   logic [fdvx_pkg::LEN_W-1:0]    rem_dec;

   // length byte: 7 bits plus continuation, or 8 bits in the last slot
   assign len_full = (len_cnt_ff >= LEN_LAST_CNT);
   assign len_bits = len_full ? in_byte : {1'b0, in_byte[6:0]};

   always_comb begin
      case (len_cnt_ff)
         2'd0:    len_shift = 5'd0;
         2'd1:    len_shift = 5'd7;
         2'd2:    len_shift = 5'd14;
         default: len_shift = 5'd21;
      endcase
   end

   assign len_part = {{(fdvx_pkg::LEN_W - fdvx_pkg::BYTE_W){1'b0}}, len_bits} << len_shift;
   assign len_new  = len_ff | len_part;
   assign rem_dec  = rem_ff - fdvx_pkg::LEN_W'(1);

   // next state and result
   always_comb begin
      phase_in   = phase_ff;
      pid_in     = pid_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      len_cnt_in = len_cnt_ff;
      rem_in     = rem_ff;
      csum_in    = csum_ff;
      res.valid           = 1'b0;
      res.rsp.kind        = fdvx_pkg::KIND_HEADER;
      res.rsp.data_byte   = '0;
      res.rsp.checksum_ok = 1'b0;

      unique case (phase_ff)
         PH_HUNT2: begin
            if (in_byte == sync.second) begin
               csum_in  = csum_ff ^ in_byte;
               phase_in = PH_PKTID;
            end else if (in_byte == sync.first) begin
               csum_in = in_byte;
            end else begin
               phase_in = PH_HUNT1;
            end
         end
         PH_PKTID: begin
            pid_in   = in_byte;
            csum_in  = csum_ff ^ in_byte;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in     = in_byte;
            csum_in    = csum_ff ^ in_byte;
            len_in     = '0;
            len_cnt_in = '0;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            csum_in = csum_ff ^ in_byte;
            len_in  = len_new;
            if (!len_full && in_byte[7]) begin
               len_cnt_in = len_cnt_ff + 2'd1;
            end else begin
               rem_in    = len_new;
               phase_in  = (len_new == '0) ? PH_CSUM : PH_BODY;
               res.valid = 1'b1;
            end
         end
         PH_BODY: begin
            csum_in  = csum_ff ^ in_byte;
            rem_in   = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_CSUM;
            end
            res.valid         = 1'b1;
            res.rsp.kind      = fdvx_pkg::KIND_BODY;
            res.rsp.data_byte = in_byte;
         end
         PH_CSUM: begin
            phase_in            = PH_HUNT1;
            res.valid           = 1'b1;
            res.rsp.kind        = fdvx_pkg::KIND_END;
            res.rsp.checksum_ok = (in_byte == csum_ff);
         end
         default: begin
            // hunting for the first sync byte; unused code behaves the same
            phase_in = PH_HUNT1;
            if (in_byte == sync.first) begin
               csum_in  = in_byte;
               phase_in = PH_HUNT2;
            end
         end
      endcase

      // ids and length as they stand after this byte
      res.rsp.packet_id   = pid_in;
      res.rsp.command     = cmd_in;
      res.rsp.body_length = len_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT1;
         pid_ff     <= '0;
         cmd_ff     <= '0;
         len_ff     <= '0;
         len_cnt_ff <= '0;
         rem_ff     <= '0;
         csum_ff    <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         pid_ff     <= pid_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         len_cnt_ff <= len_cnt_in;
         rem_ff     <= rem_in;
         csum_ff    <= csum_in;
      end
   end

endmodule

// ===== hdl/fdvx_skid.sv =====
// ----------------------------------------------------------------------------
// fdvx_skid - result register with skid stage
// Output register plus one spare entry so a request can be taken while a
// result waits; input stall comes from the spare entry only.
// ----------------------------------------------------------------------------
module fdvx_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fdvx_pkg::rsp_type   push_rsp,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output fdvx_pkg::rsp_type   out_rsp
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   fdvx_pkg::rsp_type out_ff, out_in;
   fdvx_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop = out_valid_ff & ~out_stall;

   // refill order: spare entry first, then new result
   always_comb begin
      out_valid_in  = out_valid_ff & ~pop;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_rsp;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

endmodule

// ===== hdl/frame_deframer_varint_xor.sv =====
// ----------------------------------------------------------------------------
// frame_deframer_varint_xor - sync header deframer, varint length, XOR check
// Byte stream in, header / body byte / frame end requests out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received byte per request (req_valid / req_stall).
//   rsp_*  : result requests: kind 0 header (id, command, body length),
//            kind 1 one body byte, kind 2 frame end with checksum_ok.
//   csr_*  : register writes, index 0 first sync byte, 1 second sync byte;
//            always ready, other indexes ignored. Write only while idle.
//   Throughput is one byte per cycle; the per-byte parser is a single
//   state update and the only limit is the output side taking results.
//   Results are registered: into the output register, or into the spare entry while it holds one.
//   Bytes of sync, id, command and non-final length produce no result.
//   Receiver stall: the output register holds the result and a spare
//   entry takes one more; req_stall rises only when both are full and
//   drops the cycle after the receiver takes a result.
//   Reset (synchronous): parser back to sync hunt, checksum and length
//   cleared, sync registers zero, output empty.
// ----------------------------------------------------------------------------
module frame_deframer_varint_xor (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fdvx_pkg::BYTE_W-1:0]          req_in_byte,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_kind,
   output logic [fdvx_pkg::BYTE_W-1:0]          rsp_packet_id,
   output logic [fdvx_pkg::BYTE_W-1:0]          rsp_command,
   output logic [fdvx_pkg::LEN_W-1:0]           rsp_body_length,
   output logic [fdvx_pkg::BYTE_W-1:0]          rsp_data_byte,
   output logic                                 rsp_checksum_ok,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fdvx_pkg::IDX_W-1:0]           csr_index,
   input  logic [fdvx_pkg::BYTE_W-1:0]          csr_data
);

   fdvx_pkg::sync_type sync;
   fdvx_pkg::res_type  res;
   fdvx_pkg::rsp_type  out_rsp;
   logic               take;
   logic               skid_full;

   assign take      = req_valid & ~skid_full;
   assign req_stall = skid_full;

   // configuration registers
   fdvx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sync      (sync)
   );

   // frame parser
   fdvx_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .sync    (sync),
      .res     (res)
   );

   // output register and skid entry
   fdvx_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (take & res.valid),
      .push_rsp  (res.rsp),
      .full      (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rsp   (out_rsp)
   );

   assign rsp_kind        = out_rsp.kind;
   assign rsp_packet_id   = out_rsp.packet_id;
   assign rsp_command     = out_rsp.command;
   assign rsp_body_length = out_rsp.body_length;
   assign rsp_data_byte   = out_rsp.data_byte;
   assign rsp_checksum_ok = out_rsp.checksum_ok;

   // spare entry only fills behind a held output
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output register");

   // full buffer stays full while the receiver stalls
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (req_stall && rsp_stall) |=> req_stall)
      else $error("buffer drained while receiver stalled");

   // data byte only carried by body results
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != fdvx_pkg::KIND_BODY) |-> (rsp_data_byte == '0))
      else $error("data byte set on non-body result");

   // checksum verdict only on frame end
   a_ok_end_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != fdvx_pkg::KIND_END) |-> !rsp_checksum_ok)
      else $error("checksum flag set on non-end result");

endmodule
